// ===== rtl/core/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// stbs_pkg: shared definitions for the sorted table search unit
// Table sizing, transaction payload types, operation and query mode codes.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int ELEMENT_WIDTH = 32;
  localparam int VALUE_W       = 32;
  localparam int INDEX_W       = 10;
  localparam int ADDR_W        = $clog2(TABLE_DEPTH);
  localparam int CNT_W         = ADDR_W + 1;
  // signed table position, holds -1 .. 2*TABLE_DEPTH+1
  localparam int POS_W         = ADDR_W + 3;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [2:0] MODE_ANY_EQ      = 3'd0;
  localparam logic [2:0] MODE_FIRST_GT    = 3'd1;
  localparam logic [2:0] MODE_LAST_EQ_GT  = 3'd2;
  localparam logic [2:0] MODE_LAST_LT     = 3'd3;
  localparam logic [2:0] MODE_FIRST_EQ_GT = 3'd4;
  localparam logic [2:0] MODE_LAST_EQ_LT  = 3'd5;
  localparam logic [2:0] MODE_FIRST_EQ_LT = 3'd6;

  typedef struct packed {
    logic [1:0]                operation;
    logic signed [VALUE_W-1:0] value;
    logic [2:0]                mode;
  } stbs_req_t;

  typedef struct packed {
    logic signed [INDEX_W-1:0] index;
    logic                      status;
  } stbs_resp_t;

  function automatic logic signed [ELEMENT_WIDTH-1:0] to_element(
    input logic signed [VALUE_W-1:0] v
  );
    return ELEMENT_WIDTH'(v);
  endfunction

endpackage

// ===== rtl/core/stbs_mem.sv =====
// ----------------------------------------------------------------------------
// stbs_mem: element table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stbs_mem (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [stbs_pkg::ADDR_W-1:0]               wr_addr,
  input  logic signed [stbs_pkg::ELEMENT_WIDTH-1:0] wr_data,
  input  logic                                      rd_en,
  input  logic [stbs_pkg::ADDR_W-1:0]               rd_addr,
  output logic signed [stbs_pkg::ELEMENT_WIDTH-1:0] rd_data
);
  import stbs_pkg::*;

  logic signed [ELEMENT_WIDTH-1:0] mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/sorted_table_bisection_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_table_bisection_search_unit: bisection search over a loaded table
// Software loads a non-decreasing table; queries return lower/upper bounds or an equal match.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken on a clock edge with start high and busy
//   low. Clear and append complete in that cycle; busy never rises and no
//   response is produced. Append on a full table is dropped.
//   A query yields exactly one response: done pulses for one cycle with
//   index and status valid; busy rises unless the table is empty or the
//   mode is unused. The receiver cannot stall; done is a single-cycle
//   strobe and must be sampled then.
//   Each probe of a bisection uses the single table read port, addressing
//   in S_LOOP and then comparing in S_CMP. A bisection over n entries
//   makes k <= floor(log2(n))+1 probes. An empty table or an unused mode
//   is answered from idle with no search; other modes run one bisection,
//   and some add a neighbor check and a second bisection.
//   Reset empties the table (count to zero) and leaves the unit idle; the
//   stored words are not cleared and are never read before being rewritten.
// ----------------------------------------------------------------------------
module sorted_table_bisection_search_unit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  stbs_pkg::stbs_req_t    request,
  output logic                   done,
  output stbs_pkg::stbs_resp_t   response
);
  import stbs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOP = 4'b0010,
    S_CMP  = 4'b0100,
    S_NB   = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    KIND_FG = 2'd0,
    KIND_LL = 2'd1,
    KIND_AE = 2'd2
  } kind_t;

  localparam logic signed [POS_W-1:0] POS_NONE = '1;
  localparam logic signed [POS_W-1:0] POS_ZERO = '0;
  localparam logic signed [POS_W-1:0] POS_ONE  = POS_W'(1);

  state_t                          state, state_next;
  kind_t                           kind, kind_next;
  logic                            second, second_next;
  logic [2:0]                      mode, mode_next;
  logic signed [ELEMENT_WIDTH-1:0] target, target_next;
  logic [CNT_W-1:0]                count, count_next;
  logic signed [POS_W-1:0]         l, l_next, r, r_next;
  logic signed [POS_W-1:0]         mid, mid_next, save, save_next;
  logic                            done_next;
  stbs_resp_t                      resp_next;

  logic                            wr_en, rd_en;
  logic [ADDR_W-1:0]               rd_addr;
  logic signed [ELEMENT_WIDTH-1:0] rd_data;

  logic signed [POS_W-1:0]         n_pos, sum, probe, nb_dn, nb_up;
  logic                            loop_go, lt, eq;
  logic                            go_valid, fin_valid, fin_status;
  kind_t                           go_kind;
  logic signed [POS_W-1:0]         fin_idx;

  stbs_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (to_element(request.value)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign busy    = (state != S_IDLE);
  assign n_pos   = signed'(POS_W'(count));
  assign loop_go = (kind == KIND_AE) ? (l <= r) : (l < r);
  assign sum     = l + r + ((kind == KIND_LL) ? POS_ONE : POS_ZERO);
  assign probe   = sum >>> 1;
  assign nb_dn   = l - POS_ONE;
  assign nb_up   = l + POS_ONE;
  // shared comparator: target against the word just read
  assign lt      = (target < rd_data);
  assign eq      = (target == rd_data);

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    second_next = second;
    mode_next   = mode;
    target_next = target;
    count_next  = count;
    l_next      = l;
    r_next      = r;
    mid_next    = mid;
    save_next   = save;
    done_next   = 1'b0;
    resp_next   = response;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = mid[ADDR_W-1:0];
    go_valid    = 1'b0;
    go_kind     = KIND_FG;
    fin_valid   = 1'b0;
    fin_status  = 1'b0;
    fin_idx     = POS_NONE;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.operation)
            OP_CLEAR: begin
              count_next = '0;
            end
            OP_APPEND: begin
              if (count < CNT_W'(TABLE_DEPTH)) begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            OP_QUERY: begin
              target_next = to_element(request.value);
              mode_next   = request.mode;
              second_next = 1'b0;
              if (count == '0) begin
                fin_valid  = 1'b1;
                fin_status = 1'b1;
              end else begin
                unique case (request.mode)
                  MODE_ANY_EQ: begin
                    go_valid = 1'b1;
                    go_kind  = KIND_AE;
                  end
                  MODE_FIRST_GT, MODE_LAST_EQ_GT, MODE_LAST_EQ_LT: begin
                    go_valid = 1'b1;
                    go_kind  = KIND_FG;
                  end
                  MODE_LAST_LT, MODE_FIRST_EQ_GT, MODE_FIRST_EQ_LT: begin
                    go_valid = 1'b1;
                    go_kind  = KIND_LL;
                  end
                  default: begin
                    fin_valid = 1'b1;
                  end
                endcase
              end
            end
            default: ;
          endcase
        end
      end

      S_LOOP: begin
        if (loop_go) begin
          mid_next   = probe;
          rd_en      = 1'b1;
          rd_addr    = probe[ADDR_W-1:0];
          state_next = S_CMP;
        end else if (kind == KIND_AE) begin
          fin_valid = 1'b1;
        end else if (second) begin
          fin_valid = 1'b1;
          fin_idx   = l;
        end else begin
          save_next = l;
          unique case (mode)
            MODE_FIRST_GT, MODE_LAST_LT: begin
              fin_valid = 1'b1;
              fin_idx   = l;
            end
            MODE_LAST_EQ_GT, MODE_LAST_EQ_LT: begin
              if (l > POS_ZERO) begin
                mid_next   = nb_dn;
                rd_en      = 1'b1;
                rd_addr    = nb_dn[ADDR_W-1:0];
                state_next = S_NB;
              end else if (mode == MODE_LAST_EQ_GT) begin
                fin_valid = 1'b1;
                fin_idx   = l;
              end else begin
                go_valid    = 1'b1;
                go_kind     = KIND_LL;
                second_next = 1'b1;
              end
            end
            MODE_FIRST_EQ_GT, MODE_FIRST_EQ_LT: begin
              if (l < n_pos - POS_ONE) begin
                mid_next   = nb_up;
                rd_en      = 1'b1;
                rd_addr    = nb_up[ADDR_W-1:0];
                state_next = S_NB;
              end else if (mode == MODE_FIRST_EQ_LT) begin
                fin_valid = 1'b1;
                fin_idx   = l;
              end else begin
                go_valid    = 1'b1;
                go_kind     = KIND_FG;
                second_next = 1'b1;
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end

      S_CMP: begin
        state_next = S_LOOP;
        unique case (kind)
          KIND_FG: begin
            if (!lt) begin
              l_next = mid + POS_ONE;
            end else begin
              r_next = mid;
            end
          end
          KIND_LL: begin
            if (lt || eq) begin
              r_next = mid - POS_ONE;
            end else begin
              l_next = mid;
            end
          end
          KIND_AE: begin
            if (eq) begin
              fin_valid = 1'b1;
              fin_idx   = mid;
            end else if (lt) begin
              r_next = mid - POS_ONE;
            end else begin
              l_next = mid + POS_ONE;
            end
          end
          default: begin
            fin_valid = 1'b1;
          end
        endcase
      end

      S_NB: begin
        unique case (mode)
          MODE_LAST_EQ_GT, MODE_FIRST_EQ_LT: begin
            fin_valid = 1'b1;
            fin_idx   = eq ? mid : save;
          end
          MODE_LAST_EQ_LT: begin
            if (eq) begin
              fin_valid = 1'b1;
              fin_idx   = mid;
            end else begin
              go_valid    = 1'b1;
              go_kind     = KIND_LL;
              second_next = 1'b1;
            end
          end
          MODE_FIRST_EQ_GT: begin
            if (eq) begin
              fin_valid = 1'b1;
              fin_idx   = mid;
            end else begin
              go_valid    = 1'b1;
              go_kind     = KIND_FG;
              second_next = 1'b1;
            end
          end
          default: begin
            fin_valid = 1'b1;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (go_valid) begin
      kind_next  = go_kind;
      l_next     = (go_kind == KIND_LL) ? POS_NONE : POS_ZERO;
      r_next     = (go_kind == KIND_FG) ? n_pos : (n_pos - POS_ONE);
      state_next = S_LOOP;
    end

    if (fin_valid) begin
      done_next        = 1'b1;
      resp_next.index  = INDEX_W'(fin_idx);
      resp_next.status = fin_status;
      state_next       = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    kind     <= kind_next;
    second   <= second_next;
    mode     <= mode_next;
    target   <= target_next;
    l        <= l_next;
    r        <= r_next;
    mid      <= mid_next;
    save     <= save_next;
    response <= resp_next;
  end

`ifndef SYNTH
  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start)))
    else $error("done without a query transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("table count past depth");

  a_probe_in_table: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (!mid[POS_W-1] && (mid < n_pos)))
    else $error("probe outside loaded entries");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    (done && response.status) |-> (response.index == '1))
    else $error("empty status with an index");
`endif

endmodule
